>>> src/lzwd_pkg.sv
// Shared definitions for the LZSS window decoder: window geometry, command codes
// and the fill pattern of the history window.
// No dependencies.
package lzwd_pkg;

    localparam int WIN_DEPTH = 4096;
    localparam int WIN_AW    = $clog2(WIN_DEPTH);

    localparam logic [WIN_AW-1:0] WIN_LAST  = WIN_AW'(WIN_DEPTH - 1);
    localparam logic [WIN_AW-1:0] START_POS = 12'hFEE;

    localparam logic [1:0] CMD_NONE = 2'd0;
    localparam logic [1:0] CMD_LIT  = 2'd1;
    localparam logic [1:0] CMD_RUN  = 2'd2;

    localparam logic [4:0] RUN_BIAS = 5'd3;

    typedef struct packed {
        logic [1:0]        kind;
        logic              fill;
        logic [7:0]        data;
        logic [WIN_AW-1:0] pos;
        logic [4:0]        len;
    } cmd_t;

    // Fill value of one window entry; quot is the entry address divided by 13,
    // kept by the caller as a running count.
    function automatic logic [7:0] fill_byte(input logic [WIN_AW-1:0] addr,
                                             input logic [7:0] quot);
        logic [7:0] val;
        val = 8'h00;
        if (addr < 12'hD00) begin
            val = quot;
        end else if (addr[11:8] == 4'hD) begin
            val = addr[7:0];
        end else if (addr[11:8] == 4'hE) begin
            val = 8'hFF - addr[7:0];
        end else if (addr < 12'hF80) begin
            val = 8'h00;
        end else if (addr < START_POS) begin
            val = 8'h20;
        end
        return val;
    endfunction

endpackage

>>> src/lzwd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lzwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/lzwd_parser.sv
// Stream parser: header length, flag bits and token assembly, one beat at a time.
// Depends on lzwd_pkg; sends at most one command per accepted beat to the engine.
module lzwd_parser (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          accept,
    input  logic [7:0]    in_byte,
    input  logic          frame_start,
    output lzwd_pkg::cmd_t cmd
);
    import lzwd_pkg::*;

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_ITEM   = 3'd1;
    localparam logic [2:0] PH_LIT    = 3'd2;
    localparam logic [2:0] PH_TOKLO  = 3'd3;
    localparam logic [2:0] PH_TOKHI  = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  flags_reg, flags_next;
    logic [3:0]  left_reg, left_next;
    logic [7:0]  tok_reg, tok_next;
    logic [31:0] enc_reg, enc_next;
    logic [31:0] count_reg, count_next;

    logic [2:0]  ph;
    logic [31:0] taken;
    logic [31:0] enc;
    logic [31:0] enc_acc;
    logic [7:0]  flags;
    logic [3:0]  left;
    logic [3:0]  left_dec;
    logic [7:0]  tok;

    always_comb begin
        ph    = frame_start ? PH_HEADER : phase_reg;
        taken = frame_start ? 32'd0 : count_reg;
        enc   = frame_start ? 32'd0 : enc_reg;
        flags = frame_start ? 8'd0 : flags_reg;
        left  = frame_start ? 4'd1 : left_reg;
        tok   = frame_start ? 8'd0 : tok_reg;

        phase_next = ph;
        flags_next = flags;
        left_next  = left;
        tok_next   = tok;
        enc_next   = enc;
        enc_acc    = enc;
        left_dec   = left - 4'd1;

        cmd.kind = CMD_NONE;
        cmd.fill = frame_start;
        cmd.data = in_byte;
        cmd.pos  = {in_byte[7:4], tok};
        cmd.len  = {1'b0, in_byte[3:0]} + RUN_BIAS;

        unique case (ph)
            PH_HEADER: begin
                if (taken[31:2] == 30'd0) begin
                    enc_acc[{taken[1:0], 3'b000} +: 8] = in_byte;
                end
                enc_next = enc_acc;
                if (taken >= 32'd7) begin
                    enc_next   = enc_acc + 32'd8;
                    left_next  = 4'd1;
                    phase_next = PH_ITEM;
                end
            end
            PH_ITEM: begin
                if (taken >= enc) begin
                    phase_next = PH_DONE;
                end else if (left_dec == 4'd0) begin
                    flags_next = {1'b0, in_byte[7:1]};
                    left_next  = 4'd8;
                    phase_next = in_byte[0] ? PH_LIT : PH_TOKLO;
                end else begin
                    left_next  = left_dec;
                    flags_next = {1'b0, flags[7:1]};
                    if (flags[0]) begin
                        cmd.kind = CMD_LIT;
                    end else begin
                        tok_next   = in_byte;
                        phase_next = PH_TOKHI;
                    end
                end
            end
            PH_LIT: begin
                cmd.kind   = CMD_LIT;
                phase_next = PH_ITEM;
            end
            PH_TOKLO: begin
                tok_next   = in_byte;
                phase_next = PH_TOKHI;
            end
            PH_TOKHI: begin
                cmd.kind   = CMD_RUN;
                phase_next = PH_ITEM;
            end
            default: begin
            end
        endcase

        count_next = (taken != 32'hFFFF_FFFF) ? taken + 32'd1 : taken;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            flags_reg <= 8'd0;
            left_reg  <= 4'd1;
            tok_reg   <= 8'd0;
            enc_reg   <= 32'd0;
            count_reg <= 32'd0;
        end else if (accept) begin
            phase_reg <= phase_next;
            flags_reg <= flags_next;
            left_reg  <= left_next;
            tok_reg   <= tok_next;
            enc_reg   <= enc_next;
            count_reg <= count_next;
        end
    end

endmodule

>>> src/lzwd_engine.sv
// Window sequencer: refill sweep, literal store and run copy through one window RAM,
// with the output register. Depends on lzwd_pkg and lzwd_ram.
module lzwd_engine (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           accept,
    input  lzwd_pkg::cmd_t cmd,
    output logic           ready,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,
    output logic           m_tlast
);
    import lzwd_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_FILL = 3'd1;
    localparam logic [2:0] ST_LIT  = 3'd2;
    localparam logic [2:0] ST_RD   = 3'd3;
    localparam logic [2:0] ST_WR   = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [WIN_AW-1:0] fill_reg, fill_next;
    logic [7:0]        quot_reg, quot_next;
    logic [3:0]        rem13_reg, rem13_next;
    logic [WIN_AW-1:0] wpos_reg, wpos_next;
    logic [WIN_AW-1:0] cpos_reg, cpos_next;
    logic [4:0]        left_reg, left_next;
    logic [7:0]        lit_reg, lit_next;
    logic              valid_reg, valid_next;
    logic [7:0]        data_reg, data_next;
    logic              last_reg, last_next;

    logic              out_free;
    logic              we;
    logic [WIN_AW-1:0] waddr;
    logic [7:0]        wdata;
    logic [7:0]        rdata;

    lzwd_ram #(
        .WIDTH(8),
        .DEPTH(WIN_DEPTH)
    ) u_window (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (cpos_reg),
        .rdata (rdata)
    );

    assign out_free = !valid_reg || m_tready;
    assign ready    = (state_reg == ST_IDLE);
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        quot_next  = quot_reg;
        rem13_next = rem13_reg;
        wpos_next  = wpos_reg;
        cpos_next  = cpos_reg;
        left_next  = left_reg;
        lit_next   = lit_reg;
        valid_next = valid_reg && !m_tready;
        data_next  = data_reg;
        last_next  = last_reg;
        we         = 1'b0;
        waddr      = wpos_reg;
        wdata      = lit_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (cmd.fill) begin
                        state_next = ST_FILL;
                        fill_next  = '0;
                        quot_next  = 8'd0;
                        rem13_next = 4'd0;
                        wpos_next  = START_POS;
                    end else if (cmd.kind == CMD_LIT) begin
                        lit_next   = cmd.data;
                        state_next = ST_LIT;
                    end else if (cmd.kind == CMD_RUN) begin
                        cpos_next  = cmd.pos;
                        left_next  = cmd.len;
                        state_next = ST_RD;
                    end
                end
            end
            ST_FILL: begin
                we        = 1'b1;
                waddr     = fill_reg;
                wdata     = fill_byte(fill_reg, quot_reg);
                fill_next = fill_reg + 1'b1;
                if (rem13_reg == 4'd12) begin
                    rem13_next = 4'd0;
                    quot_next  = quot_reg + 8'd1;
                end else begin
                    rem13_next = rem13_reg + 4'd1;
                end
                if (fill_reg == WIN_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_LIT: begin
                if (out_free) begin
                    we         = 1'b1;
                    wdata      = lit_reg;
                    wpos_next  = wpos_reg + 1'b1;
                    valid_next = 1'b1;
                    data_next  = lit_reg;
                    last_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_RD: begin
                state_next = ST_WR;
            end
            ST_WR: begin
                if (out_free) begin
                    we         = 1'b1;
                    wdata      = rdata;
                    wpos_next  = wpos_reg + 1'b1;
                    cpos_next  = cpos_reg + 1'b1;
                    left_next  = left_reg - 5'd1;
                    valid_next = 1'b1;
                    data_next  = rdata;
                    last_next  = (left_reg == 5'd1);
                    state_next = (left_reg == 5'd1) ? ST_IDLE : ST_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_FILL;
            fill_reg  <= '0;
            quot_reg  <= 8'd0;
            rem13_reg <= 4'd0;
            wpos_reg  <= START_POS;
            cpos_reg  <= '0;
            left_reg  <= 5'd0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            quot_reg  <= quot_next;
            rem13_reg <= rem13_next;
            wpos_reg  <= wpos_next;
            cpos_reg  <= cpos_next;
            left_reg  <= left_next;
            valid_reg <= valid_next;
        end
        lit_reg  <= lit_next;
        data_reg <= data_next;
        last_reg <= last_next;
    end

endmodule

>>> src/lzwd_window_decoder.sv
// Top level of the LZSS window decoder: stream ports, parser and window engine.
// Depends on lzwd_pkg, lzwd_parser and lzwd_engine.
//
// The decoder takes one compressed byte per input beat and returns decoded bytes,
// with m_tlast on the last byte that a given input beat produces. All window
// traffic goes through one 4096-byte RAM with one write port and a registered read
// port, and that port sets the timing. Header, flag and token-low bytes leave the
// engine idle, a literal passes through a store state, and a match goes through a
// read state and a write state for each copied byte. After reset, and after
// every beat with the frame start flag set, the window is refilled with its initial
// pattern, during which s_tready stays low. A pending output beat does not hold off
// the next input beat unless that beat needs the output register.
module lzss_window_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte[7:0]
    input  logic       s_tuser,   // frame_start
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte[7:0]
    output logic       m_tlast    // run_last
);
    import lzwd_pkg::*;

    logic accept;
    cmd_t cmd;

    assign accept = s_tvalid && s_tready;

    lzwd_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .in_byte     (s_tdata),
        .frame_start (s_tuser),
        .cmd         (cmd)
    );

    lzwd_engine u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .cmd      (cmd),
        .ready    (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for lzss_window_decoder: streams compressed frames in,
// predicts every decoded byte from its own window copy and checks the output beats.
// Depends on lzwd_pkg and the decoder RTL.
module testbench;

    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 600;
    localparam int LEN_EXACT   = 0;
    localparam int LEN_CUT     = 1;
    localparam int LEN_SHORT   = 2;
    localparam int LEN_HUGE    = 3;
    localparam int LEN_ABORT   = 4;

    typedef enum logic [2:0] {
        PH_HEADER, PH_ITEM, PH_LITERAL, PH_TOKEN_LO, PH_TOKEN_HI, PH_STOPPED
    } decode_phase_t;

    typedef struct packed {
        logic       start;
        logic [7:0] data;
    } stream_byte_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } decoded_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tuser  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    stream_byte_t stream_q [$];
    decoded_t     expected_out [$];
    stream_byte_t send_beat;
    decoded_t     want;

    int          stream_made  = 0;
    int          inputs_taken = 0;
    int          hold_cycles  = 0;
    int          cycles       = 0;
    int          mismatches   = 0;
    logic        calm;
    logic        hold_on;
    logic [11:0] gen_wpos;

    // Decoder state as the stream has left it.
    logic [7:0]    window_mem [0:lzwd_pkg::WIN_DEPTH-1];
    logic [11:0]   wr_pos;
    logic [11:0]   cp_pos;
    logic [7:0]    flag_bits;
    logic [3:0]    bits_left;
    logic [7:0]    tok_lo;
    logic [31:0]   enc_end;
    logic [31:0]   stream_count;
    decode_phase_t phase;

    lzss_window_decoder i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    assign calm    = inputs_taken >= 140 && inputs_taken < 190;
    assign hold_on = inputs_taken >= 100 && hold_cycles < HOLD_CYCLES;

    task automatic restart_decoder();
        for (int i = 0; i < 'hD00; i++) window_mem[i] = 8'(i / 13);
        for (int i = 0; i < 256; i++) begin
            window_mem['hD00 + i] = 8'(i);
            window_mem['hE00 + i] = 8'(255 - i);
        end
        for (int i = 'hF00; i < 'hF80; i++) window_mem[i] = 8'h00;
        for (int i = 'hF80; i < 'hFEE; i++) window_mem[i] = 8'h20;
        for (int i = 'hFEE; i < 'h1000; i++) window_mem[i] = 8'h00;
        wr_pos       = lzwd_pkg::START_POS;
        cp_pos       = '0;
        flag_bits    = '0;
        bits_left    = 4'd1;
        tok_lo       = '0;
        enc_end      = '0;
        stream_count = '0;
        phase        = PH_HEADER;
    endtask

    task automatic emit_byte(input logic [7:0] b, input logic last);
        window_mem[wr_pos] = b;
        wr_pos = wr_pos + 12'd1;
        expected_out.push_back('{data: b, last: last});
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic start);
        logic [31:0] taken;
        logic        bit0;
        int          len;
        if (start) restart_decoder();
        taken = stream_count;
        case (phase)
            PH_HEADER: begin
                if (taken < 4) enc_end = enc_end | (32'(b) << (8 * taken[1:0]));
                if (taken >= 7) begin
                    enc_end   = enc_end + 32'd8;
                    bits_left = 4'd1;
                    phase     = PH_ITEM;
                end
            end
            PH_ITEM: begin
                if (taken >= enc_end) begin
                    phase = PH_STOPPED;
                end else begin
                    bits_left = bits_left - 4'd1;
                    if (bits_left == 4'd0) begin
                        bits_left = 4'd8;
                        bit0      = b[0];
                        flag_bits = b >> 1;
                        phase     = bit0 ? PH_LITERAL : PH_TOKEN_LO;
                    end else begin
                        bit0      = flag_bits[0];
                        flag_bits = flag_bits >> 1;
                        if (bit0) begin
                            emit_byte(b, 1'b1);
                        end else begin
                            tok_lo = b;
                            phase  = PH_TOKEN_HI;
                        end
                    end
                end
            end
            PH_LITERAL: begin
                emit_byte(b, 1'b1);
                phase = PH_ITEM;
            end
            PH_TOKEN_LO: begin
                tok_lo = b;
                phase  = PH_TOKEN_HI;
            end
            PH_TOKEN_HI: begin
                cp_pos = {b[7:4], tok_lo};
                len    = int'(b[3:0]) + 3;
                for (int k = 0; k < len; k++) begin
                    emit_byte(window_mem[cp_pos], k == len - 1);
                    cp_pos = cp_pos + 12'd1;
                end
                phase = PH_ITEM;
            end
            default: begin
            end
        endcase
        if (stream_count != 32'hFFFF_FFFF) stream_count = stream_count + 32'd1;
    endtask

    task automatic put_frame(input logic start, input int n_items, input int mode);
        logic [7:0]  body [$];
        logic [7:0]  frame [$];
        logic [7:0]  flags;
        logic [11:0] pos;
        logic [31:0] enc_len;
        int          len;
        int          flag_end;
        int          n_push;
        int          lit_pct;
        lit_pct  = $urandom_range(20, 80);
        flags    = 8'h00;
        flag_end = 0;
        gen_wpos = lzwd_pkg::START_POS;
        for (int k = 0; k < n_items; k++) begin
            if (k % 8 == 0) begin
                for (int j = 0; j < 8; j++) flags[j] = $urandom_range(99) < lit_pct;
                body.push_back(flags);
                flag_end = body.size();
            end
            if (flags[k % 8]) begin
                body.push_back(8'($urandom_range(255)));
                gen_wpos = gen_wpos + 12'd1;
            end else begin
                case ($urandom_range(7))
                    0, 1:    pos = gen_wpos - 12'($urandom_range(1, 18));
                    2:       pos = $urandom_range(1) ? 12'hFFF : 12'h000;
                    default: pos = 12'($urandom_range(4095));
                endcase
                if ($urandom_range(3) == 0) len = $urandom_range(1) ? 18 : 3;
                else len = $urandom_range(3, 18);
                body.push_back(pos[7:0]);
                body.push_back({pos[11:8], 4'(len - 3)});
                gen_wpos = gen_wpos + 12'(len);
            end
        end
        case (mode)
            LEN_CUT:   enc_len = flag_end;
            LEN_SHORT: enc_len = $urandom_range(0, body.size());
            LEN_HUGE:  enc_len = 32'hFFFF_FFF8 + 32'($urandom_range(7));
            default:   enc_len = body.size();
        endcase
        for (int i = 0; i < 4; i++) frame.push_back(enc_len[8*i +: 8]);
        for (int i = 0; i < 4; i++) frame.push_back(8'($urandom_range(255)));
        frame  = {frame, body};
        n_push = (mode == LEN_ABORT) ? $urandom_range(1, frame.size()) : frame.size();
        for (int i = 0; i < n_push; i++) begin
            stream_q.push_back('{start: start && i == 0, data: frame[i]});
        end
        stream_made += n_push;
        if (mode != LEN_ABORT) begin
            repeat ($urandom_range(2)) begin
                stream_q.push_back('{start: 1'b0, data: 8'($urandom_range(255))});
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                decode_byte(s_tdata, s_tuser);
                inputs_taken <= inputs_taken + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (stream_q.size() != 0 && (calm || $urandom_range(99) >= 38)) begin
                    send_beat = stream_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= send_beat.data;
                    s_tuser  <= send_beat.start;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && hold_on) begin
            hold_cycles <= hold_cycles + 1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !hold_on && (calm || $urandom_range(99) >= 38);
            if (m_tvalid && m_tready) begin
                if (expected_out.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual data %02h last %0b",
                             $time, m_tdata, m_tlast);
                    mismatches++;
                end else begin
                    want = expected_out.pop_front();
                    if (m_tdata !== want.data) begin
                        $display("%0t: out_byte expected %02h actual %02h",
                                 $time, want.data, m_tdata);
                        mismatches++;
                    end
                    if (m_tlast !== want.last) begin
                        $display("%0t: run_last expected %0b actual %0b",
                                 $time, want.last, m_tlast);
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        logic [7:0] opening [0:22];
        int         pick;
        int         mode;
        int         round;
        restart_decoder();
        // Literals at both extremes, matches at the window ends, a self-overlapping
        // match and one from the ramp region; the last two beats fall past the end.
        opening = '{8'h0D, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                    8'h63, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h04,
                    8'h0F, 8'h5A, 8'hA5, 8'h00, 8'hD7, 8'h80, 8'h7F};
        foreach (opening[i]) stream_q.push_back('{start: 1'b0, data: opening[i]});
        stream_made = 23;
        round = 0;
        while (stream_made < 220) begin
            pick = $urandom_range(99);
            if (round == 0) mode = LEN_CUT;
            else if (round == 1) mode = LEN_HUGE;
            else if (pick < 55) mode = LEN_EXACT;
            else if (pick < 70) mode = LEN_CUT;
            else if (pick < 82) mode = LEN_SHORT;
            else if (pick < 88) mode = LEN_HUGE;
            else mode = LEN_ABORT;
            put_frame(round < 2 || $urandom_range(9) != 0, $urandom_range(0, 24), mode);
            round++;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        while (stream_q.size() != 0 || s_tvalid || expected_out.size() != 0) begin
            @(posedge aclk);
        end
        repeat (100) @(posedge aclk);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
